// ===== src/pmte_pkg.sv =====
package pmte_pkg;

   // field widths
   localparam int CoordWidth    = 28;
   localparam int SpeedWidth    = 24;
   localparam int DelayWidth    = 22;
   localparam int DlyWidth      = DelayWidth + 1;
   localparam int LenWidth      = 48;
   localparam int TotalWidth    = 63;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 24;

   // arithmetic datapath widths
   localparam int MulWidth  = 28;
   localparam int ProdWidth = 2 * MulWidth;
   localparam int SumWidth  = 58;
   localparam int RootWidth = 29;
   localparam int IterWidth = 76;
   localparam int RemWidth  = 30;
   localparam int StepWidth = 7;

   localparam logic [StepWidth-1:0]  SqrtSteps     = 7'd29;
   localparam logic [StepWidth-1:0]  DivSteps      = 7'd76;
   localparam logic [SpeedWidth-1:0] SpeedFallback = 24'd76800;
   localparam logic [MulWidth-1:0]   NsNum         = 28'd250000000;
   localparam logic [MulWidth-1:0]   DelayNs       = 28'd1000;
   localparam logic [TotalWidth-1:0] TotalMax      = '1;
   localparam logic [LenWidth-1:0]   LenMax        = '1;
   // smallest quotient whose whole-second part overflows the total
   localparam logic [IterWidth-1:0]  QuotSat       = 76'd9223372037000000000;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SPEED     = 2'd0,
      CSR_ON_DELAY  = 2'd1,
      CSR_OFF_DELAY = 2'd2
   } csr_index_type;

   typedef enum logic {
      ITER_SQRT = 1'b0,
      ITER_DIV  = 1'b1
   } iter_mode_type;

   typedef struct packed {
      logic          start;
      iter_mode_type mode;
   } iter_ctl_type;

endpackage

// ===== src/pmte_ifs.sv =====
interface pmte_req_if import pmte_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [CoordWidth-1:0] pos_x;
   logic signed [CoordWidth-1:0] pos_y;
   logic signed [CoordWidth-1:0] pos_z;
   logic                         seg_first;
   logic                         seg_last;
   logic                         is_mark;
   logic                         use_override;
   logic [SpeedWidth-1:0]        over_speed;
   logic [DelayWidth-1:0]        over_on_delay;
   logic [DelayWidth-1:0]        over_off_delay;
   logic                         restart;

   modport source (
      output valid, pos_x, pos_y, pos_z, seg_first, seg_last, is_mark, use_override,
             over_speed, over_on_delay, over_off_delay, restart,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, pos_z, seg_first, seg_last, is_mark, use_override,
             over_speed, over_on_delay, over_off_delay, restart,
      output ready
   );
endinterface

interface pmte_rsp_if import pmte_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TotalWidth-1:0] total_ns;
   logic                  saturated;

   modport source (output valid, total_ns, saturated, input ready);
   modport sink (input valid, total_ns, saturated, output ready);
endinterface

interface pmte_csr_if import pmte_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [CsrDataWidth-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/path_motion_time_estimator_core.sv =====
// path motion time estimator
// req_ch carries one path point per beat with its segment marks, per-segment overrides
// and a restart flag; rsp_ch returns one beat per point: the running job time in ns
// and a sticky saturation flag. csr_ch writes the default speed and laser delays; it
// is always ready and should only be used while the block is idle
// one point at a time: req_ch.ready is high only while the sequencer is idle
// a point that opens a segment goes from idle straight to the output state
// any other point waits on the shared root unit (29 steps of two radicand bits) after
// three squares through the shared multiplier
// a segment's last point then makes two partial products of length times 250e6 and
// runs a 76-step division by the speed in the same unit; a mark segment then adds
// the delays through the multiplier
// the result sits in an output register, so a stalled receiver only holds the block
// once the next result is finished and the register is still full
// reset clears the job total, the open segment, the defaults and the output beat

module path_motion_time_estimator_core import pmte_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pmte_req_if.sink  req_ch,
   pmte_rsp_if.source rsp_ch,
   pmte_csr_if.sink  csr_ch
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DIST   = 8'b0000_0010,
      ST_SQRT   = 8'b0000_0100,
      ST_SEGMUL = 8'b0000_1000,
      ST_DIV    = 8'b0001_0000,
      ST_DLYMUL = 8'b0010_0000,
      ST_DLYADD = 8'b0100_0000,
      ST_OUT    = 8'b1000_0000
   } state_type;

   // saturating add into the job total, returns {overflow, total}
   function automatic logic [TotalWidth:0] sat_add(input logic [TotalWidth-1:0] acc,
                                                    input logic [TotalWidth:0]   inc);
      logic [TotalWidth+1:0] sum;
      sum = {2'b0, acc} + {1'b0, inc};
      if (sum > {2'b0, TotalMax}) begin
         sat_add = {1'b1, TotalMax};
      end else begin
         sat_add = {1'b0, sum[TotalWidth-1:0]};
      end
   endfunction

   state_type state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;

   // defaults
   logic [SpeedWidth-1:0] cfg_speed_ff, cfg_speed_in;
   logic [DelayWidth-1:0] cfg_on_ff, cfg_on_in;
   logic [DelayWidth-1:0] cfg_off_ff, cfg_off_in;

   // point being worked on
   logic [CoordWidth-1:0] cur_x_ff, cur_x_in;
   logic [CoordWidth-1:0] cur_y_ff, cur_y_in;
   logic [CoordWidth-1:0] cur_z_ff, cur_z_in;
   logic                  last_ff, last_in;
   logic                  mark_ff, mark_in;
   logic [SpeedWidth-1:0] spd_ff, spd_in;
   logic [DlyWidth-1:0]   dly_ff, dly_in;

   // estimator state
   logic [CoordWidth-1:0] prev_x_ff, prev_x_in;
   logic [CoordWidth-1:0] prev_y_ff, prev_y_in;
   logic [CoordWidth-1:0] prev_z_ff, prev_z_in;
   logic [LenWidth-1:0]   seg_len_ff, seg_len_in;
   logic                  open_ff, open_in;
   logic                  multi_ff, multi_in;
   logic [TotalWidth-1:0] total_ff, total_in;
   logic                  sat_ff, sat_in;

   // datapath scratch
   logic [SumWidth-1:0]        sum_ff, sum_in;
   logic [ProdWidth-5:0]       hi_ff, hi_in;

   // output beat
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TotalWidth-1:0] rsp_total_ff, rsp_total_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   // shared units
   logic [MulWidth-1:0]   mul_a, mul_b;
   logic [ProdWidth-1:0]  mul_p;
   iter_ctl_type          iter_ctl;
   logic [IterWidth-1:0]  iter_opnd;
   logic                  iter_done;
   logic [IterWidth-1:0]  iter_res;

   // working values
   logic [CoordWidth-1:0] sel_cur, sel_prev;
   logic [CoordWidth:0]   diff, diff_mag;
   logic [SumWidth-1:0]   sum_next;
   logic [LenWidth:0]     len_sum;
   logic                  quot_sat;
   logic [TotalWidth:0]   seg_ns;
   logic [TotalWidth:0]   add_seg, add_dly;
   logic [SpeedWidth-1:0] spd_pick;
   logic                  accept;

   pmte_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   pmte_iter u_iter (
      .clock   (clock),
      .reset   (reset),
      .ctl     (iter_ctl),
      .opnd    (iter_opnd),
      .divisor (spd_ff),
      .done    (iter_done),
      .result  (iter_res)
   );

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign accept           = req_ch.valid && req_ch.ready;
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.total_ns  = rsp_total_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

   // coordinate pair for the square being issued
   always_comb begin
      unique case (cnt_ff)
         2'd0: begin
            sel_cur  = cur_x_ff;
            sel_prev = prev_x_ff;
         end
         2'd1: begin
            sel_cur  = cur_y_ff;
            sel_prev = prev_y_ff;
         end
         default: begin
            sel_cur  = cur_z_ff;
            sel_prev = prev_z_ff;
         end
      endcase
      diff     = {sel_cur[CoordWidth-1], sel_cur} - {sel_prev[CoordWidth-1], sel_prev};
      diff_mag = diff[CoordWidth] ? (~diff + 1'b1) : diff;
   end

   assign sum_next = sum_ff + {2'b0, mul_p};
   assign len_sum  = {1'b0, seg_len_ff} + {{(LenWidth+1-RootWidth){1'b0}},
                                             iter_res[RootWidth-1:0]};
   // whole seconds beyond the total force it to saturate
   assign quot_sat = (iter_res >= QuotSat);
   assign seg_ns   = quot_sat ? {1'b0, TotalMax} : iter_res[TotalWidth:0];
   assign add_seg  = sat_add(total_ff, seg_ns);
   assign add_dly  = sat_add(total_ff, {8'b0, mul_p});

   // speed of 0 falls back to 300 mm/s
   always_comb begin
      spd_pick = req_ch.use_override ? req_ch.over_speed : cfg_speed_ff;
      if (spd_pick == '0) begin
         spd_pick = SpeedFallback;
      end
   end

   // configuration writes
   always_comb begin
      cfg_speed_in = cfg_speed_ff;
      cfg_on_in    = cfg_on_ff;
      cfg_off_in   = cfg_off_ff;
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_SPEED:     cfg_speed_in = csr_ch.data;
            CSR_ON_DELAY:  cfg_on_in    = csr_ch.data[DelayWidth-1:0];
            CSR_OFF_DELAY: cfg_off_in   = csr_ch.data[DelayWidth-1:0];
            default:       cfg_speed_in = cfg_speed_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_z_in     = cur_z_ff;
      last_in      = last_ff;
      mark_in      = mark_ff;
      spd_in       = spd_ff;
      dly_in       = dly_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      prev_z_in    = prev_z_ff;
      seg_len_in   = seg_len_ff;
      open_in      = open_ff;
      multi_in     = multi_ff;
      total_in     = total_ff;
      sat_in       = sat_ff;
      sum_in       = sum_ff;
      hi_in        = hi_ff;
      rsp_total_in = rsp_total_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      mul_a        = '0;
      mul_b        = '0;
      iter_ctl     = '{start: 1'b0, mode: ITER_SQRT};
      iter_opnd    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.restart) begin
                  total_in = '0;
                  sat_in   = 1'b0;
               end
               cur_x_in = req_ch.pos_x;
               cur_y_in = req_ch.pos_y;
               cur_z_in = req_ch.pos_z;
               last_in  = req_ch.seg_last;
               mark_in  = req_ch.is_mark;
               spd_in   = spd_pick;
               dly_in   = req_ch.use_override
                        ? {1'b0, req_ch.over_on_delay} + {1'b0, req_ch.over_off_delay}
                        : {1'b0, cfg_on_ff} + {1'b0, cfg_off_ff};
               if (req_ch.seg_first || !open_ff) begin
                  // new segment, nothing to measure yet
                  seg_len_in = '0;
                  open_in    = !req_ch.seg_last;
                  multi_in   = 1'b0;
                  prev_x_in  = req_ch.pos_x;
                  prev_y_in  = req_ch.pos_y;
                  prev_z_in  = req_ch.pos_z;
                  state_in   = ST_OUT;
               end else begin
                  sum_in   = '0;
                  cnt_in   = 2'd0;
                  state_in = ST_DIST;
               end
            end
         end
         ST_DIST: begin
            // squares issued on counts 0..2, each product is summed on the next count
            mul_a  = diff_mag[CoordWidth-1:0];
            mul_b  = diff_mag[CoordWidth-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != 2'd0) begin
               sum_in = sum_next;
            end
            if (cnt_ff == 2'd3) begin
               iter_ctl  = '{start: 1'b1, mode: ITER_SQRT};
               iter_opnd = {sum_next, {(IterWidth-SumWidth){1'b0}}};
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (iter_done) begin
               if (len_sum[LenWidth]) begin
                  seg_len_in = LenMax;
                  sat_in     = 1'b1;
               end else begin
                  seg_len_in = len_sum[LenWidth-1:0];
               end
               multi_in  = 1'b1;
               prev_x_in = cur_x_ff;
               prev_y_in = cur_y_ff;
               prev_z_in = cur_z_ff;
               cnt_in    = 2'd0;
               state_in  = last_ff ? ST_SEGMUL : ST_OUT;
            end
         end
         ST_SEGMUL: begin
            // length times 250e6 as two 24-bit halves
            mul_b  = NsNum;
            cnt_in = cnt_ff + 1'b1;
            unique case (cnt_ff)
               2'd0: mul_a = {4'b0, seg_len_ff[LenWidth-1 -: SpeedWidth]};
               2'd1: begin
                  mul_a = {4'b0, seg_len_ff[SpeedWidth-1:0]};
                  hi_in = mul_p[ProdWidth-5:0];
               end
               default: begin
                  iter_ctl  = '{start: 1'b1, mode: ITER_DIV};
                  iter_opnd = {hi_ff, {SpeedWidth{1'b0}}}
                            + {{(IterWidth-ProdWidth){1'b0}}, mul_p};
                  cnt_in    = 2'd0;
                  state_in  = ST_DIV;
               end
            endcase
         end
         ST_DIV: begin
            if (iter_done) begin
               total_in   = add_seg[TotalWidth-1:0];
               sat_in     = sat_ff || quot_sat || add_seg[TotalWidth];
               seg_len_in = '0;
               open_in    = 1'b0;
               multi_in   = 1'b0;
               state_in   = mark_ff ? ST_DLYMUL : ST_OUT;
            end
         end
         ST_DLYMUL: begin
            mul_a    = {{(MulWidth-DlyWidth){1'b0}}, dly_ff};
            mul_b    = DelayNs;
            state_in = ST_DLYADD;
         end
         ST_DLYADD: begin
            total_in = add_dly[TotalWidth-1:0];
            sat_in   = sat_ff || add_dly[TotalWidth];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = total_ff;
               rsp_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cfg_speed_ff <= '0;
         cfg_on_ff    <= '0;
         cfg_off_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         seg_len_ff   <= '0;
         open_ff      <= 1'b0;
         multi_ff     <= 1'b0;
         total_ff     <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cfg_speed_ff <= cfg_speed_in;
         cfg_on_ff    <= cfg_on_in;
         cfg_off_ff   <= cfg_off_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         prev_z_ff    <= prev_z_in;
         seg_len_ff   <= seg_len_in;
         open_ff      <= open_in;
         multi_ff     <= multi_in;
         total_ff     <= total_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      cur_z_ff     <= cur_z_in;
      last_ff      <= last_in;
      mark_ff      <= mark_in;
      spd_ff       <= spd_in;
      dly_ff       <= dly_in;
      sum_ff       <= sum_in;
      hi_ff        <= hi_in;
      rsp_total_ff <= rsp_total_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

endmodule

// ===== src/pmte_mul.sv =====
module pmte_mul import pmte_pkg::*; (
   input  logic                 clock,
   input  logic [MulWidth-1:0]  mul_a,
   input  logic [MulWidth-1:0]  mul_b,
   output logic [ProdWidth-1:0] mul_p
);

   logic [ProdWidth-1:0] prod_ff;
   logic [ProdWidth-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

// ===== src/pmte_iter.sv =====
module pmte_iter import pmte_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  iter_ctl_type          ctl,
   input  logic [IterWidth-1:0]  opnd,
   input  logic [SpeedWidth-1:0] divisor,
   output logic                  done,
   output logic [IterWidth-1:0]  result
);

   // one restoring step per cycle: two radicand bits for the root, one dividend bit for
   // the quotient, both through the same compare and subtract

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [StepWidth-1:0]  cnt_ff, cnt_in;
   iter_mode_type         mode_ff, mode_in;
   logic [IterWidth-1:0]  op_ff, op_in;
   logic [IterWidth-1:0]  res_ff, res_in;
   logic [RemWidth-1:0]   rem_ff, rem_in;
   logic [SpeedWidth-1:0] div_ff, div_in;

   logic [31:0] cand;
   logic [31:0] trial;
   logic [32:0] diff;
   logic        ge;

   always_comb begin
      unique case (mode_ff)
         ITER_SQRT: begin
            cand  = {rem_ff, op_ff[IterWidth-1 -: 2]};
            trial = {1'b0, res_ff[RootWidth-1:0], 2'b01};
         end
         ITER_DIV: begin
            cand  = {7'b0, rem_ff[SpeedWidth-1:0], op_ff[IterWidth-1]};
            trial = {8'b0, div_ff};
         end
         default: begin
            cand  = '0;
            trial = '0;
         end
      endcase
      diff = {1'b0, cand} - {1'b0, trial};
      ge   = !diff[32];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      op_in   = op_ff;
      res_in  = res_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         mode_in = ctl.mode;
         cnt_in  = (ctl.mode == ITER_SQRT) ? SqrtSteps : DivSteps;
         op_in   = opnd;
         res_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[RemWidth-1:0] : cand[RemWidth-1:0];
         res_in = {res_ff[IterWidth-2:0], ge};
         op_in  = (mode_ff == ITER_SQRT) ? {op_ff[IterWidth-3:0], 2'b00}
                                         : {op_ff[IterWidth-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         mode_ff <= ITER_SQRT;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      res_ff <= res_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== src/pmte_checker.sv =====
module pmte_checker import pmte_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [TotalWidth-1:0] rsp_total_ns,
   input logic                  rsp_saturated
);

   // output register empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // one point at a time: an accepted beat drops ready
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held after accepting a point");

   // a new result only appears as the sequencer returns to idle
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result beat raised while a point is in progress");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_ns)
                                  && $stable(rsp_saturated))
      else $error("stalled result beat changed");

endmodule

bind path_motion_time_estimator_core pmte_checker u_pmte_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_total_ns  (rsp_ch.total_ns),
   .rsp_saturated (rsp_ch.saturated)
);

// ===== bench/path_motion_time_estimator_core_tb.sv =====
`timescale 1ns / 1ps

module path_motion_time_estimator_core_tb;
   import pmte_pkg::*;

   // generous watchdog for ~600 points plus stalls and gaps
   localparam int unsigned CycleLimit = 400000;
   // quiet cycles after the last result, enough for one full segment end
   localparam int unsigned TailCycles = 200;
   localparam int unsigned PhaseItems = 70;

   localparam logic signed [CoordWidth-1:0] CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};
   localparam logic signed [CoordWidth-1:0] CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
   localparam longint unsigned TotalCap = 64'(TotalMax);
   localparam longint unsigned LenCap   = 64'(LenMax);

   typedef struct {
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] y;
      logic signed [CoordWidth-1:0] z;
      bit                           first;
      bit                           last;
      bit                           mark;
      bit                           ovr;
      logic [SpeedWidth-1:0]        speed;
      logic [DelayWidth-1:0]        on_us;
      logic [DelayWidth-1:0]        off_us;
      bit                           restart;
   } path_point_type;

   typedef struct {
      logic [TotalWidth-1:0] ns;
      logic                  sat;
   } job_time_type;

   typedef struct {
      path_point_type pt;
      bit             typed;
      job_time_type   want;
   } probe_row_type;

   logic clock;
   logic reset;

   pmte_req_if req_ch ();
   pmte_rsp_if rsp_ch ();
   pmte_csr_if csr_ch ();

   path_motion_time_estimator_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // job time predictor state, mirrors the block after reset
   logic signed [CoordWidth-1:0] anchor_x = '0;
   logic signed [CoordWidth-1:0] anchor_y = '0;
   logic signed [CoordWidth-1:0] anchor_z = '0;
   longint unsigned open_len = 0;
   int unsigned     open_pts = 0;   // 0 closed, 1 one point, 2 two or more
   longint unsigned job_ns   = 0;
   logic            job_sat  = 1'b0;
   logic [SpeedWidth-1:0] cfg_speed  = '0;
   logic [DelayWidth-1:0] cfg_on_us  = '0;
   logic [DelayWidth-1:0] cfg_off_us = '0;

   job_time_type   pending_times[$];
   probe_row_type  probe_rows[$];

   bit          gaps_on = 1'b1;
   int unsigned cycle_count = 0;
   int unsigned faults = 0;
   int unsigned results_seen = 0;
   int unsigned sat_results = 0;
   int unsigned points_sent = 0;
   int unsigned restarts_sent = 0;
   int unsigned reg_writes = 0;

   // ---------------------------------------------------------------- clock, reset

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned span(logic signed [CoordWidth-1:0] a,
                                            logic signed [CoordWidth-1:0] b);
      longint sa;
      longint sb;
      sa = a;
      sb = b;
      return (sa >= sb) ? longint'(sa - sb) : longint'(sb - sa);
   endfunction

   // exact floor square root, two radicand bits per pass
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe >>= 2;
      while (probe != 0) begin
         if (n >= root + probe) begin
            n    = n - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   function automatic void add_to_job(longint unsigned v);
      if (v > TotalCap - job_ns) begin
         job_ns  = TotalCap;
         job_sat = 1'b1;
      end else begin
         job_ns += v;
      end
   endfunction

   function automatic job_time_type estimate_job_time(path_point_type p);
      longint unsigned dx, dy, dz, hop;
      longint unsigned spd, on_us, off_us, q, r, t;
      job_time_type res;
      if (p.restart) begin
         job_ns  = 0;
         job_sat = 1'b0;
      end
      // a point with no open segment opens one, first mark or not
      if (p.first || open_pts == 0) begin
         open_len = 0;
         open_pts = 1;
      end else begin
         dx  = span(p.x, anchor_x);
         dy  = span(p.y, anchor_y);
         dz  = span(p.z, anchor_z);
         hop = int_sqrt(dx * dx + dy * dy + dz * dz);
         if (hop > LenCap - open_len) begin
            open_len = LenCap;
            job_sat  = 1'b1;
         end else begin
            open_len += hop;
         end
         open_pts = 2;
      end
      anchor_x = p.x;
      anchor_y = p.y;
      anchor_z = p.z;
      if (p.last) begin
         if (open_pts == 2) begin
            spd    = p.ovr ? p.speed  : cfg_speed;
            on_us  = p.ovr ? p.on_us  : cfg_on_us;
            off_us = p.ovr ? p.off_us : cfg_off_us;
            if (spd == 0) spd = SpeedFallback;
            q = open_len / spd;
            r = open_len % spd;
            // integer-quotient part alone already past the top of the total
            if (q > TotalCap / NsNum) begin
               t       = TotalCap;
               job_sat = 1'b1;
            end else begin
               t = q * NsNum + (r * NsNum) / spd;
            end
            add_to_job(t);
            if (p.mark) add_to_job((on_us + off_us) * DelayNs);
         end
         open_pts = 0;
         open_len = 0;
      end
      res.ns  = job_ns[TotalWidth-1:0];
      res.sat = job_sat;
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic path_point_type point_of(
      logic signed [CoordWidth-1:0] x, logic signed [CoordWidth-1:0] y,
      logic signed [CoordWidth-1:0] z,
      bit first, bit last, bit mark, bit ovr,
      logic [SpeedWidth-1:0] speed, logic [DelayWidth-1:0] on_us,
      logic [DelayWidth-1:0] off_us, bit restart);
      path_point_type p;
      p.x = x;  p.y = y;  p.z = z;
      p.first = first;  p.last = last;  p.mark = mark;  p.ovr = ovr;
      p.speed = speed;  p.on_us = on_us;  p.off_us = off_us;
      p.restart = restart;
      return p;
   endfunction

   function automatic void add_probe(path_point_type p, bit typed,
                                     logic [TotalWidth-1:0] ns, logic sat);
      probe_row_type row;
      row.pt      = p;
      row.typed   = typed;
      row.want.ns = ns;
      row.want.sat = sat;
      probe_rows.push_back(row);
   endfunction

   // mix of full-range jumps, extremes and short and medium moves from the last point
   function automatic logic signed [CoordWidth-1:0] next_coord(
      logic signed [CoordWidth-1:0] base);
      case ($urandom_range(0, 9))
         0, 1:    return CoordWidth'($urandom());
         2:       return $urandom_range(0, 1) ? CoordMax : CoordMin;
         3, 4, 5: return CoordWidth'(base + $urandom_range(0, 2046) - 1023);
         default: return CoordWidth'(base + $urandom_range(0, 2 ** 21) - 2 ** 20);
      endcase
   endfunction

   function automatic logic [SpeedWidth-1:0] pick_speed();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return SpeedWidth'($urandom_range(1, 255));
         3:       return SpeedFallback;
         default: return SpeedWidth'($urandom());
      endcase
   endfunction

   function automatic logic [DelayWidth-1:0] pick_delay();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return DelayWidth'($urandom_range(0, 100));
         default: return DelayWidth'($urandom());
      endcase
   endfunction

   function automatic void report_fault(string msg);
      faults++;
      if (faults <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endfunction

   // ---------------------------------------------------------------- drivers

   // valid stays up from one beat to the next; it only drops in an idle cycle
   task automatic send_point(path_point_type p);
      while (gaps_on && $urandom_range(0, 99) < 21) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.pos_x          <= p.x;
      req_ch.pos_y          <= p.y;
      req_ch.pos_z          <= p.z;
      req_ch.seg_first      <= p.first;
      req_ch.seg_last       <= p.last;
      req_ch.is_mark        <= p.mark;
      req_ch.use_override   <= p.ovr;
      req_ch.over_speed     <= p.speed;
      req_ch.over_on_delay  <= p.on_us;
      req_ch.over_off_delay <= p.off_us;
      req_ch.restart        <= p.restart;
      do @(posedge clock); while (!req_ch.ready);
      pending_times.push_back(estimate_job_time(p));
      points_sent++;
      if (p.restart) restarts_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_times.size() != 0);
   endtask

   task automatic load_defaults(logic [CsrDataWidth-1:0] spd,
                                logic [CsrDataWidth-1:0] on_d,
                                logic [CsrDataWidth-1:0] off_d);
      csr_index_type           regs[3];
      logic [CsrDataWidth-1:0] vals[3];
      regs = '{CSR_SPEED, CSR_ON_DELAY, CSR_OFF_DELAY};
      vals = '{spd, on_d, off_d};
      for (int i = 0; i < 3; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= regs[i];
         csr_ch.data  <= vals[i];
         do @(posedge clock); while (!csr_ch.ready);
         case (regs[i])
            CSR_SPEED:     cfg_speed  = vals[i][SpeedWidth-1:0];
            CSR_ON_DELAY:  cfg_on_us  = vals[i][DelayWidth-1:0];
            CSR_OFF_DELAY: cfg_off_us = vals[i][DelayWidth-1:0];
            default: ;
         endcase
         reg_writes++;
      end
      csr_ch.valid <= 1'b0;
   endtask

   // one segment of npts points; a haul bounces between opposite corners at the
   // slowest speed so the segment time or the job total runs into saturation
   task automatic run_segment(int unsigned npts, bit haul);
      path_point_type p;
      for (int unsigned i = 0; i < npts; i++) begin
         p.restart = haul ? 1'b0 : ($urandom_range(0, 29) == 0);
         p.mark    = ($urandom_range(0, 1) == 1);
         p.ovr     = haul || ($urandom_range(0, 2) != 0);
         p.speed   = haul ? SpeedWidth'(1) : pick_speed();
         p.on_us   = pick_delay();
         p.off_us  = pick_delay();
         if (haul) begin
            p.first = (i == 0);
            p.last  = (i == npts - 1);
            // corner to corner, jitter only in the low bits
            p.x = (i % 2) ? CoordWidth'(CoordMax - $urandom_range(0, 1023))
                          : CoordWidth'(CoordMin + $urandom_range(0, 1023));
            p.y = (i % 2) ? CoordWidth'(CoordMax - $urandom_range(0, 1023))
                          : CoordWidth'(CoordMin + $urandom_range(0, 1023));
            p.z = (i % 2) ? CoordWidth'(CoordMax - $urandom_range(0, 1023))
                          : CoordWidth'(CoordMin + $urandom_range(0, 1023));
         end else begin
            // mostly clean segments; now and then a missing or stray first mark or a missing last
            p.first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
            p.last  = (i == npts - 1) && ($urandom_range(0, 11) != 0);
            p.x = next_coord(anchor_x);
            p.y = next_coord(anchor_y);
            p.z = next_coord(anchor_z);
         end
         send_point(p);
      end
   endtask

   // ---------------------------------------------------------------- receiver, checker

   always @(posedge clock) rsp_ch.ready <= !gaps_on || ($urandom_range(0, 99) >= 21);

   always @(posedge clock) begin : check_results
      job_time_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (rsp_ch.saturated) sat_results++;
         if (pending_times.size() == 0) begin
            report_fault($sformatf("unexpected beat total_ns=%0d saturated=%0b",
                                   rsp_ch.total_ns, rsp_ch.saturated));
         end else begin
            want = pending_times.pop_front();
            if (rsp_ch.total_ns !== want.ns)
               report_fault($sformatf("total_ns expected %0d got %0d",
                                      want.ns, rsp_ch.total_ns));
            if (rsp_ch.saturated !== want.sat)
               report_fault($sformatf("saturated expected %0b got %0b (total_ns %0d)",
                                      want.sat, rsp_ch.saturated, want.ns));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, pending_times.size());
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin : stimulus
      int unsigned start;
      bit          paused;

      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.pos_x          <= '0;
      req_ch.pos_y          <= '0;
      req_ch.pos_z          <= '0;
      req_ch.seg_first      <= 1'b0;
      req_ch.seg_last       <= 1'b0;
      req_ch.is_mark        <= 1'b0;
      req_ch.use_override   <= 1'b0;
      req_ch.over_speed     <= '0;
      req_ch.over_on_delay  <= '0;
      req_ch.over_off_delay <= '0;
      req_ch.restart        <= 1'b0;
      csr_ch.valid          <= 1'b0;
      csr_ch.index          <= CSR_SPEED;
      csr_ch.data           <= '0;

      // directed points, run with the reset defaults (speed 0 means 300 mm/s, no delays)
      //                  x         y         z     fst lst mrk ovr speed    on   off  rst
      add_probe(point_of(0,        0,        0,        1, 0, 0, 0, 0,       0,   0,   0),
                1, 0, 0);                                    // straight out of reset
      add_probe(point_of(76800,    0,        0,        0, 1, 1, 0, 0,       0,   0,   0),
                1, 250000000, 0);                            // 75 mm at 300 mm/s
      add_probe(point_of(CoordMin, CoordMin, CoordMin, 1, 0, 0, 1, '1,      '1,  '1,  1),
                1, 0, 0);                                    // restart clears the total
      add_probe(point_of(CoordMax, CoordMax, CoordMax, 0, 1, 1, 1, '1,      '1,  '1,  0),
                0, 0, 0);                                    // widest step, longest delays
      add_probe(point_of(CoordMax, CoordMin, 0,        1, 1, 1, 1, 1,       '1,  '1,  0),
                0, 0, 0);                                    // one-point segment adds nothing
      add_probe(point_of(5,        -7,       3,        0, 0, 1, 1, 1,       0,   0,   0),
                0, 0, 0);                                    // opens a segment without a first mark
      add_probe(point_of(1029,     -7,       3,        0, 1, 1, 1, 0,       1,   2,   0),
                0, 0, 0);                                    // zero override speed falls back
      add_probe(point_of(100,      100,      100,      1, 0, 0, 0, 0,       0,   0,   0),
                0, 0, 0);
      add_probe(point_of(-100,     300,      100,      0, 0, 0, 0, 0,       0,   0,   0),
                0, 0, 0);
      add_probe(point_of(7,        7,        7,        1, 0, 1, 1, 1,       0,   0,   0),
                0, 0, 0);                                    // first mark drops the open segment
      add_probe(point_of(3007,     4007,     7,        0, 1, 0, 1, 256,     '1,  '1,  0),
                0, 0, 0);                                    // non-mark: delays ignored
      add_probe(point_of(0,        0,        0,        1, 0, 0, 0, 0,       0,   0,   0),
                0, 0, 0);
      add_probe(point_of(CoordMin, 0,        0,        0, 0, 0, 0, 0,       0,   0,   0),
                0, 0, 0);
      add_probe(point_of(CoordMin, CoordMax, 0,        0, 0, 0, 0, 0,       0,   0,   1),
                0, 0, 0);                                    // restart inside a segment
      add_probe(point_of(CoordMax, CoordMax, CoordMax, 0, 1, 1, 0, '1,      '1,  '1,  0),
                0, 0, 0);                                    // register defaults used
      add_probe(point_of(42,       42,       42,       1, 0, 0, 0, 0,       0,   0,   0),
                0, 0, 0);
      add_probe(point_of(42,       42,       42,       0, 1, 1, 1, 1,       1,   1,   0),
                0, 0, 0);                                    // zero length, delays only
      add_probe(point_of(1,        2,        3,        0, 1, 1, 1, 1,       '1,  '1,  0),
                0, 0, 0);                                    // last with no segment open
      add_probe(point_of(-1,       -1,       -1,       1, 1, 1, 1, 1,       '1,  '1,  1),
                1, 0, 0);                                    // restart on a one-point segment
      add_probe(point_of(0,        0,        0,        1, 0, 0, 0, 0,       0,   0,   0),
                0, 0, 0);
      add_probe(point_of(1,        0,        0,        0, 1, 1, 1, '1,      0,   0,   0),
                0, 0, 0);                                    // shortest step at top speed
      add_probe(point_of(CoordMax, CoordMin, CoordMax, 1, 0, 0, 0, 0,       0,   0,   0),
                0, 0, 0);
      add_probe(point_of(CoordMin, CoordMax, CoordMin, 0, 1, 1, 1, 1,       0,   0,   0),
                0, 0, 0);                                    // long diagonal at the slowest speed

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_rows[i]) begin
         send_point(probe_rows[i].pt);
         // rows with a hand-worked answer replace the predicted one just queued
         if (probe_rows[i].typed) pending_times[$] = probe_rows[i].want;
      end

      // random phases, each behind a fresh set of defaults written while idle
      // the segment length clamp needs ~600k full-scale steps, out of reach here
      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         case (ph)
            0:       load_defaults('1, '1, '1);            // top of every register
            1:       load_defaults(24'd1, '0, '0);         // slowest speed, no delays
            3:       load_defaults('0, 24'h3FFFFF, '0);    // fallback speed, long on delay
            default: load_defaults(CsrDataWidth'($urandom()), CsrDataWidth'($urandom()),
                                   CsrDataWidth'($urandom()));
         endcase
         // one phase runs with both sides flat out
         gaps_on = (ph != 2);
         if (ph == 1) begin
            // two half-length hauls overflow the total between them, the long one
            // overflows the segment time on its own
            run_segment(45, 1);
            run_segment(45, 1);
            send_point(point_of(0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 1));
            run_segment(85, 1);
         end
         start  = points_sent;
         paused = 1'b0;
         while (points_sent - start < PhaseItems) begin
            if (ph == 3 && !paused && points_sent - start >= PhaseItems / 2) begin
               // hold the sender until every owed result is back
               wait_drained();
               paused = 1'b1;
            end
            if ($urandom_range(0, 99) == 0) run_segment($urandom_range(40, 90), 1);
            else                            run_segment($urandom_range(1, 6), 0);
         end
      end

      wait_drained();
      repeat (TailCycles) @(posedge clock);

      $display("%0d path points sent (%0d with restart), %0d results checked, %0d csr writes",
               points_sent, restarts_sent, results_seen, reg_writes);
      $display("%0d results carried the saturation flag; %0d mismatches in total",
               sat_results, faults);
      if (faults == 0 && pending_times.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
